@@ hw/rtl/multi_port_debounce_change_events_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multi-port debounce block
// Same-cycle and next-cycle implication checks, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_PORT_DEBOUNCE_CHANGE_EVENTS_ASSERT_SVH
`define MULTI_PORT_DEBOUNCE_CHANGE_EVENTS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MPDCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MPDCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mpdce_pkg.sv @@
// ----------------------------------------------------------------------------
// mpdce_pkg
// Shared types, constants and helpers for the multi-port debounce block.
// ----------------------------------------------------------------------------
package mpdce_pkg;

  localparam int PIN_COUNT = 16;
  localparam int PIN_W     = 4;

  typedef logic [PIN_COUNT-1:0] word_t;
  typedef logic [PIN_W-1:0]     pin_t;

  localparam word_t WORD_ALL_ONES = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic load;   // input beat accepted this cycle
    logic step;   // emit one event into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;    // accepted beat produces at least one event
    logic last;   // the event emitted now is the final one
  } dp_sts_t;

  // index of lowest set bit (0 when none set)
  function automatic pin_t lsb_index(input word_t w);
    pin_t idx;
    idx = '0;
    for (int i = PIN_COUNT - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = pin_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/mpdce_if.sv @@
// ----------------------------------------------------------------------------
// mpdce_in_if / mpdce_out_if
// Valid/ready channels for raw samples and change events.
// ----------------------------------------------------------------------------
interface mpdce_in_if import mpdce_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  port_index;
  word_t raw_sample;
  logic  sample_valid;
  logic  prime;

  modport source (output valid, port_index, raw_sample, sample_valid, prime,
                  input ready);
  modport sink   (input valid, port_index, raw_sample, sample_valid, prime,
                  output ready);
endinterface

interface mpdce_out_if import mpdce_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  event_port;
  pin_t  event_pin;
  logic  pin_active;
  word_t port_levels;
  logic  last_event;

  modport source (output valid, event_port, event_pin, pin_active, port_levels,
                  last_event, input ready);
  modport sink   (input valid, event_port, event_pin, pin_active, port_levels,
                  last_event, output ready);
endinterface

@@ hw/rtl/multi_port_debounce_change_events.sv @@
// ----------------------------------------------------------------------------
// multi_port_debounce_change_events
// Two-sample agreement debounce over several 16-pin ports, one event per
// accepted pin change, ascending pin order, last marker on the final one.
//
//   channel  | dir | payload
//   ---------+-----+--------------------------------------------------------
//   in_chan  | in  | port_index, raw_sample, sample_valid, prime
//   out_chan | out | event_port, event_pin, pin_active, port_levels, last_event
//
// A sample beat is taken while the sequencer is idle; a changing sample then
// holds the input closed while the single-pin scan over the mask emits its events (1 to 16).
// Event n+1 loads while event n is taken, so a ready sink sees one per cycle.
// Sink backpressure stalls the scan; the input reopens after the last event
// is in the output register. Reset sets both stores of every port to all ones.
// ----------------------------------------------------------------------------
module multi_port_debounce_change_events import mpdce_pkg::*; #(
  parameter int CHIPS = 2
) (
  input  logic clk,
  input  logic rst_n,
  mpdce_in_if.sink    in_chan,
  mpdce_out_if.source out_chan
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  mpdce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // stores and event datapath
  mpdce_dp #(
    .CHIPS (CHIPS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_port_index   (in_chan.port_index),
    .in_raw_sample   (in_chan.raw_sample),
    .in_sample_valid (in_chan.sample_valid),
    .in_prime        (in_chan.prime),
    .out_event_port  (out_chan.event_port),
    .out_event_pin   (out_chan.event_pin),
    .out_pin_active  (out_chan.pin_active),
    .out_port_levels (out_chan.port_levels),
    .out_last_event  (out_chan.last_event)
  );

endmodule

@@ hw/rtl/mpdce_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpdce_ctrl
// Sequencer: takes a sample beat, then steps out one event per free slot.
// ----------------------------------------------------------------------------
`include "multi_port_debounce_change_events_assert.svh"

module mpdce_ctrl import mpdce_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  // handshake and commands
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign cmd.load  = accept;
  assign cmd.step  = (state_r == ST_SCAN) & out_free;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && sts.hit) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmd.step && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    if (cmd.step) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `MPDCE_ASSERT_NOW(a_step_slot_free, clk, rst_n, cmd.step, (state_r == ST_SCAN) && (!out_valid_r || out_ready), "event stepped into a busy slot")
  `MPDCE_ASSERT_NEXT(a_last_to_idle, clk, rst_n, cmd.step && sts.last, state_r == ST_IDLE, "scan did not end on last event")
  `MPDCE_ASSERT_NEXT(a_hit_to_scan, clk, rst_n, accept && sts.hit, state_r == ST_SCAN, "changing sample did not start a scan")

endmodule

@@ hw/rtl/mpdce_dp.sv @@
// ----------------------------------------------------------------------------
// mpdce_dp
// Per-port sample/level stores, change mask and the event output register.
// ----------------------------------------------------------------------------
`include "multi_port_debounce_change_events_assert.svh"

module mpdce_dp import mpdce_pkg::*; #(
  parameter int CHIPS = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  input  logic    in_port_index,
  input  word_t   in_raw_sample,
  input  logic    in_sample_valid,
  input  logic    in_prime,
  output logic    out_event_port,
  output pin_t    out_event_pin,
  output logic    out_pin_active,
  output word_t   out_port_levels,
  output logic    out_last_event
);

  localparam int PW = (CHIPS > 1) ? $clog2(CHIPS) : 1;

  word_t           stab_r [CHIPS];
  word_t           prev_r [CHIPS];
  word_t           diff_r, levels_r;
  logic            port_r;
  logic            ev_port_r, ev_active_r, ev_last_r;
  pin_t            ev_pin_r;
  word_t           ev_levels_r;

  logic            in_range;
  logic [PW-1:0]   idx;
  word_t           prev_w, stab_w, agreed, diff, levels;
  logic            upd;
  pin_t            low_pin;
  word_t           diff_cleared;

  // port lookup
  assign in_range = (32'(in_port_index) < CHIPS);
  assign idx      = in_range ? PW'(in_port_index) : '0;
  assign prev_w   = prev_r[idx];
  assign stab_w   = stab_r[idx];

  // two-sample agreement and change mask
  assign agreed = ~(in_raw_sample ^ prev_w);
  assign diff   = (stab_w ^ in_raw_sample) & agreed;
  assign levels = (stab_w & ~agreed) | (in_raw_sample & agreed);
  assign upd    = cmd.load & in_sample_valid & in_range;

  assign sts.hit = upd & ~in_prime & (diff != '0);

  // scan: peel off the lowest pending pin
  assign low_pin      = lsb_index(diff_r);
  assign diff_cleared = diff_r & (diff_r - word_t'(1));
  assign sts.last     = (diff_cleared == '0);

  // stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHIPS; i++) begin
        stab_r[i] <= WORD_ALL_ONES;
        prev_r[i] <= WORD_ALL_ONES;
      end
    end else if (upd) begin
      prev_r[idx] <= in_raw_sample;
      stab_r[idx] <= in_prime ? in_raw_sample : levels;
    end
  end

  // pending change mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r <= '0;
    end else if (sts.hit) begin
      diff_r <= diff;
    end else if (cmd.step) begin
      diff_r <= diff_cleared;
    end
  end

  // per-sample context, no reset needed
  always_ff @(posedge clk) begin
    if (sts.hit) begin
      levels_r <= levels;
      port_r   <= in_port_index;
    end
  end

  // event output register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      ev_port_r   <= port_r;
      ev_pin_r    <= low_pin;
      ev_active_r <= ~levels_r[low_pin];
      ev_levels_r <= levels_r;
      ev_last_r   <= sts.last;
    end
  end

  assign out_event_port  = ev_port_r;
  assign out_event_pin   = ev_pin_r;
  assign out_pin_active  = ev_active_r;
  assign out_port_levels = ev_levels_r;
  assign out_last_event  = ev_last_r;

  // checks
  `MPDCE_ASSERT_NOW(a_step_has_pin, clk, rst_n, cmd.step, diff_r != '0, "step with empty change mask")
  `MPDCE_ASSERT_NEXT(a_step_one_pin, clk, rst_n, cmd.step && !sts.hit, $countones(diff_r) + 1 == $countones($past(diff_r)), "step did not retire exactly one pin")
  `MPDCE_ASSERT_NEXT(a_hit_loads_mask, clk, rst_n, sts.hit, diff_r != '0, "hit left change mask empty")

endmodule
